FILE: hdl/assert_macros.svh
// Assertion macros for the thrust mixer.
// Used by the top level; expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`endif

FILE: hdl/tmn_pkg.sv
// Shared types and constants of the thrust mixer.
// No dependencies.
package tmn_pkg;
	localparam int NUM_MOTORS = 6;
	localparam int MOTORS = 6;
	localparam int AXES = 6;
	localparam int CMD_W = 16;
	localparam int COEF_W = 10;
	localparam int PROD_W = CMD_W + COEF_W;
	localparam int SUM_W = PROD_W + 3;
	localparam int MAG_W = SUM_W - 1;
	localparam int LIM_W = 15;
	localparam int REM_W = MAG_W + LIM_W;
	localparam int Q_W = LIM_W;
	localparam int OUT_W = 16;
	localparam int ROW_W = 60;
	localparam int CFG_IDX_W = 3;
	localparam int FRAC_DROP = 6;
	localparam int QDEPTH = 8;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int NST = Q_W + 2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd6;

	typedef logic [MOTORS-1:0][ROW_W-1:0] row_mat_t;
	typedef logic [AXES-1:0][CMD_W-1:0] cmd_vec_t;
	typedef logic [MOTORS-1:0][OUT_W-1:0] thrust_vec_t;

	localparam row_mat_t ROW_RESET = {
		60'd1080863910568919104, 60'd72057594037928000, 60'd1031798784000,
		60'd69726109696, 60'd71400542961664, 60'd70438470287360
	};
	localparam logic [LIM_W-1:0] LIMIT_RESET = 15'd2560;

	typedef struct packed {
		logic scaled;
		logic [MOTORS-1:0] neg;
		logic [MOTORS-1:0][MAG_W-1:0] mag;
		logic [MAG_W-1:0] max_abs;
	} cls_t;

	typedef struct packed {
		logic scaled;
		logic [MOTORS-1:0] neg;
		logic [MAG_W-1:0] den;
		logic [MOTORS-1:0][REM_W-1:0] rem;
		logic [MOTORS-1:0][Q_W-1:0] q;
	} work_t;
endpackage

FILE: hdl/thrust_mixer_with_normalization.sv
// Thrust mixer top level: configuration registers, front end, word queue, back end.
// Depends on tmn_pkg, tmn_front, tmn_queue, tmn_back and assert_macros.svh.
//
// Takes one six-axis command word per clock while full is low and returns six motor
// thrusts per word, in order. A word passes through the front-end stages (products,
// motor sums, peak search), the 8-deep word queue and the back end, whose divider
// resolves one quotient bit per stage over 15 stages. The front end stalls only
// when the queue and its own stages hold 8 words; the back end stalls only while
// the result is not popped.
// Configuration is taken every cycle and must be written while the block is idle.
`include "assert_macros.svh"
module thrust_mixer_with_normalization (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic signed [15:0] surge_axis,
	input  logic signed [15:0] sway_axis,
	input  logic signed [15:0] heave_axis,
	input  logic signed [15:0] roll_axis,
	input  logic signed [15:0] pitch_axis,
	input  logic signed [15:0] yaw_cmd,
	output logic empty,
	input  logic pop,
	output logic signed [15:0] thrust_0,
	output logic signed [15:0] thrust_1,
	output logic signed [15:0] thrust_2,
	output logic signed [15:0] thrust_3,
	output logic signed [15:0] thrust_4,
	output logic signed [15:0] thrust_5,
	output logic was_scaled,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [tmn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tmn_pkg::ROW_W-1:0] cfg_data
);
	tmn_pkg::row_mat_t rows_q;
	logic [tmn_pkg::LIM_W-1:0] lim_q;
	tmn_pkg::cmd_vec_t cmd;
	tmn_pkg::cls_t q_din, q_dout;
	logic q_push, q_pop, q_empty;
	logic [tmn_pkg::QCNT_W-1:0] q_cnt;
	tmn_pkg::thrust_vec_t thrust;

	assign cfg_ready = 1'b1;
	assign cmd = {yaw_cmd, pitch_axis, roll_axis, heave_axis, sway_axis, surge_axis};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= tmn_pkg::ROW_RESET;
			lim_q <= tmn_pkg::LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index < tmn_pkg::CFG_IDX_W'(tmn_pkg::MOTORS)) begin
				rows_q[cfg_index] <= cfg_data;
			end else if (cfg_index == tmn_pkg::REG_LIMIT) begin
				lim_q <= cfg_data[tmn_pkg::LIM_W-1:0];
			end
		end
	end

	tmn_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd(cmd),
		.rows(rows_q), .lim(lim_q), .q_cnt(q_cnt), .q_push(q_push), .q_din(q_din)
	);

	tmn_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .din(q_din), .pop(q_pop),
		.dout(q_dout), .empty(q_empty), .cnt(q_cnt)
	);

	tmn_back u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_dout(q_dout), .q_pop(q_pop),
		.lim(lim_q), .pop(pop), .empty(empty), .thrust(thrust), .was_scaled(was_scaled)
	);

	assign thrust_0 = thrust[0];
	assign thrust_1 = thrust[1];
	assign thrust_2 = thrust[2];
	assign thrust_3 = thrust[3];
	assign thrust_4 = thrust[4];
	assign thrust_5 = thrust[5];

	`ASSERT_NEVER(a_mid_overflow, q_push && q_cnt == tmn_pkg::QCNT_W'(tmn_pkg::QDEPTH), "word queue overflow")
	`ASSERT_NEVER(a_mid_underflow, q_pop && q_empty, "word queue underflow")
	`ASSERT_CLK(a_full_when_queue_full, q_cnt == tmn_pkg::QCNT_W'(tmn_pkg::QDEPTH) |-> full, "front accepts with queue full")
endmodule

FILE: hdl/tmn_front.sv
// Front end: mixing products, motor sums, peak magnitude and scale decision.
// Depends on tmn_pkg.
module tmn_front (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  tmn_pkg::cmd_vec_t cmd,
	input  tmn_pkg::row_mat_t rows,
	input  logic [tmn_pkg::LIM_W-1:0] lim,
	input  logic [tmn_pkg::QCNT_W-1:0] q_cnt,
	output logic q_push,
	output tmn_pkg::cls_t q_din
);
	logic signed [tmn_pkg::PROD_W-1:0] prod [tmn_pkg::MOTORS][tmn_pkg::AXES];
	logic signed [tmn_pkg::PROD_W-1:0] prod_s1 [tmn_pkg::MOTORS][tmn_pkg::AXES];
	logic v_s1, v_s2, v_s3;
	logic signed [tmn_pkg::SUM_W-1:0] sum [tmn_pkg::MOTORS];
	logic [tmn_pkg::MOTORS-1:0] neg_c, neg_s2;
	logic [tmn_pkg::MOTORS-1:0][tmn_pkg::MAG_W-1:0] mag_c, mag_s2;
	logic [tmn_pkg::MAG_W-1:0] max_c;
	tmn_pkg::cls_t cls_s3;
	logic [tmn_pkg::QCNT_W:0] used;
	logic take;

	assign used = {1'b0, q_cnt} + (tmn_pkg::QCNT_W + 1)'(v_s1)
		+ (tmn_pkg::QCNT_W + 1)'(v_s2) + (tmn_pkg::QCNT_W + 1)'(v_s3);
	assign full = used >= (tmn_pkg::QCNT_W + 1)'(tmn_pkg::QDEPTH);
	assign take = push && !full;

	always_comb begin
		for (int m = 0; m < tmn_pkg::MOTORS; m++) begin
			for (int d = 0; d < tmn_pkg::AXES; d++) begin
				prod[m][d] = $signed(rows[m][d*tmn_pkg::COEF_W +: tmn_pkg::COEF_W])
					* $signed(cmd[d]);
			end
		end
	end

	always_comb begin
		for (int m = 0; m < tmn_pkg::MOTORS; m++) begin
			sum[m] = '0;
			if (m < tmn_pkg::NUM_MOTORS) begin
				for (int d = 0; d < tmn_pkg::AXES; d++) begin
					sum[m] = sum[m] + tmn_pkg::SUM_W'(prod_s1[m][d]);
				end
			end
			neg_c[m] = sum[m][tmn_pkg::SUM_W-1];
			mag_c[m] = neg_c[m] ? tmn_pkg::MAG_W'(-sum[m]) : tmn_pkg::MAG_W'(sum[m]);
		end
	end

	always_comb begin
		max_c = '0;
		for (int m = 0; m < tmn_pkg::MOTORS; m++) begin
			if (mag_s2[m] > max_c) begin
				max_c = mag_s2[m];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		neg_s2 <= neg_c;
		mag_s2 <= mag_c;
		cls_s3.neg <= neg_s2;
		cls_s3.mag <= mag_s2;
		cls_s3.max_abs <= max_c;
		cls_s3.scaled <= max_c > tmn_pkg::MAG_W'({lim, 6'b0});
	end

	assign q_push = v_s3;
	assign q_din = cls_s3;
endmodule

FILE: hdl/tmn_queue.sv
// Short word queue between the front and back ends.
// Depends on tmn_pkg.
module tmn_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tmn_pkg::cls_t din,
	input  logic pop,
	output tmn_pkg::cls_t dout,
	output logic empty,
	output logic [tmn_pkg::QCNT_W-1:0] cnt
);
	tmn_pkg::cls_t mem [tmn_pkg::QDEPTH];
	logic [tmn_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [tmn_pkg::QCNT_W-1:0] cnt_q;

	assign empty = cnt_q == '0;
	assign cnt = cnt_q;
	assign dout = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + tmn_pkg::QCNT_W'(push) - tmn_pkg::QCNT_W'(pop);
		end
	end
endmodule

FILE: hdl/tmn_back.sv
// Back end: scale by limit over peak with a bit-per-stage divider (unscaled words only
// drop fraction bits), sign, output register. Depends on tmn_pkg.
module tmn_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  tmn_pkg::cls_t q_dout,
	output logic q_pop,
	input  logic [tmn_pkg::LIM_W-1:0] lim,
	input  logic pop,
	output logic empty,
	output tmn_pkg::thrust_vec_t thrust,
	output logic was_scaled
);
	tmn_pkg::work_t st [tmn_pkg::NST];
	logic [tmn_pkg::NST-1:0] v_q;
	logic out_v_q;
	logic adv;
	tmn_pkg::thrust_vec_t thrust_q;
	logic scaled_q;

	assign adv = !out_v_q || pop;
	assign q_pop = adv && !q_empty;
	assign empty = !out_v_q;
	assign thrust = thrust_q;
	assign was_scaled = scaled_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_q <= {v_q[tmn_pkg::NST-2:0], !q_empty};
			out_v_q <= v_q[tmn_pkg::NST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st[0].scaled <= q_dout.scaled;
			st[0].neg <= q_dout.neg;
			st[0].den <= q_dout.max_abs;
			st[0].q <= '0;
			for (int m = 0; m < tmn_pkg::MOTORS; m++) begin
				st[0].rem[m] <= tmn_pkg::REM_W'(q_dout.mag[m]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st[1].scaled <= st[0].scaled;
			st[1].neg <= st[0].neg;
			st[1].den <= st[0].den;
			for (int m = 0; m < tmn_pkg::MOTORS; m++) begin
				if (st[0].scaled) begin
					st[1].rem[m] <= tmn_pkg::MAG_W'(st[0].rem[m]) * lim;
					st[1].q[m] <= '0;
				end else begin
					st[1].rem[m] <= '0;
					st[1].q[m] <= st[0].rem[m][tmn_pkg::FRAC_DROP +: tmn_pkg::Q_W];
				end
			end
		end
	end

	for (genvar k = 0; k < tmn_pkg::Q_W; k++) begin : g_div
		localparam int BIT = tmn_pkg::Q_W - 1 - k;
		logic [tmn_pkg::REM_W-1:0] dsh;
		assign dsh = tmn_pkg::REM_W'(st[k+1].den) << BIT;
		always_ff @(posedge clk) begin
			if (adv) begin
				st[k+2].scaled <= st[k+1].scaled;
				st[k+2].neg <= st[k+1].neg;
				st[k+2].den <= st[k+1].den;
				for (int m = 0; m < tmn_pkg::MOTORS; m++) begin
					st[k+2].rem[m] <= st[k+1].rem[m];
					st[k+2].q[m] <= st[k+1].q[m];
					if (st[k+1].scaled && st[k+1].rem[m] >= dsh) begin
						st[k+2].rem[m] <= st[k+1].rem[m] - dsh;
						st[k+2].q[m][BIT] <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			scaled_q <= st[tmn_pkg::NST-1].scaled;
			for (int m = 0; m < tmn_pkg::MOTORS; m++) begin
				thrust_q[m] <= st[tmn_pkg::NST-1].neg[m]
					? -tmn_pkg::OUT_W'(st[tmn_pkg::NST-1].q[m])
					: tmn_pkg::OUT_W'(st[tmn_pkg::NST-1].q[m]);
			end
		end
	end
endmodule
